### design/dle_sfe_pkg.sv
// Shared types and constants for the DLE stuffed frame encoder.
// No dependencies; used by dle_sfe_run_builder and dle_stuffed_frame_encoder.
package dle_sfe_pkg;

   localparam int ByteWidth = 8;
   localparam int MaxRun    = 8;                 // most words one item can cause
   localparam int PtrWidth  = $clog2(MaxRun);
   localparam int CntWidth  = $clog2(MaxRun + 1);
   localparam int CsrIdxWidth = 1;

   localparam logic [ByteWidth-1:0] EscapeReset = 8'h10;
   localparam logic [ByteWidth-1:0] EndReset    = 8'h03;
   localparam logic [ByteWidth-1:0] AllOnes     = 8'hFF;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic [CsrIdxWidth-1:0] CSR_ESCAPE = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_END    = 1'd1;

   typedef struct packed {
      logic                 command;
      logic [ByteWidth-1:0] packet_id;
      logic [ByteWidth-1:0] payload_length;
      logic [ByteWidth-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [ByteWidth-1:0] running_sum;
      logic [ByteWidth-1:0] bytes_left;
      logic                 frame_open;
   } frame_state_type;

   typedef struct packed {
      logic [MaxRun-1:0][ByteWidth-1:0] words;
      logic [CntWidth-1:0]              count;
      logic                             done;  // run ends with the end byte
      logic                             err;   // run is a sequence error
   } run_type;

endpackage

### design/dle_sfe_run_builder.sv
// Combinational expansion of one item into its run of framed words.
// Depends on dle_sfe_pkg.
module dle_sfe_run_builder (
   input  dle_sfe_pkg::item_type        item,
   input  dle_sfe_pkg::frame_state_type cur,
   input  logic [7:0]                   escape_byte,
   input  logic [7:0]                   end_byte,
   output dle_sfe_pkg::run_type         run,
   output dle_sfe_pkg::frame_state_type nxt
);

   always_comb begin
      logic [dle_sfe_pkg::MaxRun-1:0]                         slot_en;
      logic [dle_sfe_pkg::MaxRun-1:0][dle_sfe_pkg::ByteWidth-1:0] slot_val;
      logic [dle_sfe_pkg::ByteWidth-1:0] sum_new;
      logic [dle_sfe_pkg::ByteWidth-1:0] left_new;
      logic [dle_sfe_pkg::ByteWidth-1:0] chk;
      logic                              trail;
      logic [dle_sfe_pkg::CntWidth-1:0]  pos;

      slot_en  = '0;
      slot_val = '0;
      nxt      = cur;
      run      = '0;
      sum_new  = '0;
      left_new = '0;
      chk      = '0;
      trail    = 1'b0;

      case (item.command)
         dle_sfe_pkg::CMD_START: begin
            sum_new = item.packet_id + item.payload_length;
            chk     = (sum_new ^ dle_sfe_pkg::AllOnes) + 8'd1;
            trail   = (item.payload_length == '0);
            slot_en = {trail, trail, trail, trail && (chk == escape_byte),
                       1'b1, item.payload_length == escape_byte, 1'b1, 1'b1};
            slot_val = {end_byte, escape_byte, chk, escape_byte,
                        item.payload_length, escape_byte, item.packet_id, escape_byte};
            run.done = trail;
            nxt.running_sum = sum_new;
            nxt.bytes_left  = item.payload_length;
            nxt.frame_open  = !trail;
         end
         dle_sfe_pkg::CMD_DATA: begin
            if (cur.frame_open) begin
               sum_new  = cur.running_sum + item.data_byte;
               left_new = cur.bytes_left - 8'd1;
               chk      = (sum_new ^ dle_sfe_pkg::AllOnes) + 8'd1;
               trail    = (left_new == '0);
               slot_en  = {2'b00, trail, trail, trail, trail && (chk == escape_byte),
                           1'b1, item.data_byte == escape_byte};
               slot_val = {16'h0000, end_byte, escape_byte, chk, escape_byte,
                           item.data_byte, escape_byte};
               run.done = trail;
               nxt.running_sum = sum_new;
               nxt.bytes_left  = left_new;
               nxt.frame_open  = !trail;
            end else begin
               // no open packet: single zero word flagged as error
               slot_en[0] = 1'b1;
               run.err    = 1'b1;
            end
         end
         default: ;
      endcase

      // pack enabled slots to the front
      pos = '0;
      for (int i = 0; i < dle_sfe_pkg::MaxRun; i++) begin
         if (slot_en[i]) begin
            run.words[pos[dle_sfe_pkg::PtrWidth-1:0]] = slot_val[i];
            pos = pos + 1'b1;
         end
      end
      run.count = pos;
   end

endmodule

### design/dle_stuffed_frame_encoder.sv
// Top level of the DLE stuffed frame encoder: CSRs, frame state, run buffer
// and output register. Depends on dle_sfe_pkg and dle_sfe_run_builder.
//
//   Channel | Direction | Ports                                   | Moves
//   req     | in        | req_valid/ready, command, id, len, data | one item word
//   rsp     | out       | rsp_valid/ready, out_byte, flags        | one stream word
//   csr     | in        | csr_valid/ready, csr_index, csr_wdata   | one register word
//
// Each item expands into a run of 1..8 words, one word leaves per cycle unless rsp stalls.
// A data item makes 1-2 words (4-6 with the trailer); a start item 3-8.
// The output register is the bottleneck: a new item is taken in the same
// cycle the last word of the previous run moves into the output register.
// Reset is synchronous; it clears the frame state, the run and rsp_valid,
// and restores DLE=0x10, ETX=0x03. csr_ready is always high.
// A stall on rsp holds the run buffer, and req_ready drops unless the run is empty.
module dle_stuffed_frame_encoder (
   input  logic       clock,
   input  logic       reset,
   // item channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [7:0] req_packet_id,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_data_byte,
   // stream channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_frame_done,
   output logic       rsp_seq_error,
   // register channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [dle_sfe_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // CSRs
   logic [7:0] escape_ff, escape_in;
   logic [7:0] end_ff, end_in;

   // frame state
   dle_sfe_pkg::frame_state_type state_ff, state_in;

   // run buffer: words still to send for the current item
   logic [dle_sfe_pkg::MaxRun-1:0][7:0]   run_buf_ff, run_buf_in;
   logic [dle_sfe_pkg::PtrWidth-1:0]      run_ptr_ff, run_ptr_in;
   logic [dle_sfe_pkg::CntWidth-1:0]      run_left_ff, run_left_in;
   logic                                  run_done_ff, run_done_in;
   logic                                  run_err_ff, run_err_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_done_ff, rsp_done_in;
   logic       rsp_err_ff, rsp_err_in;

   dle_sfe_pkg::item_type        item;
   dle_sfe_pkg::run_type         run;
   dle_sfe_pkg::frame_state_type state_nxt;

   logic req_fire;
   logic out_load;
   logic run_final;

   assign item.command        = req_command;
   assign item.packet_id      = req_packet_id;
   assign item.payload_length = req_payload_length;
   assign item.data_byte      = req_data_byte;

   dle_sfe_run_builder u_builder (
      .item        (item),
      .cur         (state_ff),
      .escape_byte (escape_ff),
      .end_byte    (end_ff),
      .run         (run),
      .nxt         (state_nxt)
   );

   // output register takes a word whenever it is empty or being drained
   assign out_load  = (run_left_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign run_final = (run_left_ff == dle_sfe_pkg::CntWidth'(1));
   // next item enters as the last word of the run moves out
   assign req_ready = (run_left_ff == '0) || (run_final && out_load);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      escape_in = escape_ff;
      end_in    = end_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dle_sfe_pkg::CSR_ESCAPE: escape_in = csr_wdata;
            dle_sfe_pkg::CSR_END:    end_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      run_buf_in  = run_buf_ff;
      run_ptr_in  = run_ptr_ff;
      run_left_in = run_left_ff;
      run_done_in = run_done_ff;
      run_err_in  = run_err_ff;
      if (req_fire) begin
         state_in    = state_nxt;
         run_buf_in  = run.words;
         run_ptr_in  = '0;
         run_left_in = run.count;
         run_done_in = run.done;
         run_err_in  = run.err;
      end else if (out_load) begin
         run_ptr_in  = run_ptr_ff + 1'b1;
         run_left_in = run_left_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_err_in   = rsp_err_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = run_buf_ff[run_ptr_ff];
         rsp_last_in  = run_final;
         rsp_done_in  = run_final && run_done_ff;
         rsp_err_in   = run_final && run_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff    <= dle_sfe_pkg::EscapeReset;
         end_ff       <= dle_sfe_pkg::EndReset;
         state_ff     <= '0;
         run_left_ff  <= '0;
         run_ptr_ff   <= '0;
         run_done_ff  <= 1'b0;
         run_err_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         escape_ff    <= escape_in;
         end_ff       <= end_in;
         state_ff     <= state_in;
         run_left_ff  <= run_left_in;
         run_ptr_ff   <= run_ptr_in;
         run_done_ff  <= run_done_in;
         run_err_ff   <= run_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_buf_ff  <= run_buf_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_frame_done  = rsp_done_ff;
   assign rsp_seq_error   = rsp_err_ff;

   // every item leaves a non-empty run behind
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> run_left_ff != '0)
      else $error("accepted item produced an empty run");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_left_ff <= dle_sfe_pkg::CntWidth'(dle_sfe_pkg::MaxRun))
      else $error("run length exceeds buffer");

   // a packet is open exactly while payload words are still owed
   a_open_left: assert property (@(posedge clock) disable iff (reset)
      state_ff.frame_open == (state_ff.bytes_left != '0))
      else $error("frame_open and bytes_left disagree");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_done || rsp_seq_error) |-> rsp_last_of_run)
      else $error("end or error word not last of run");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_error |-> rsp_out_byte == '0 && !rsp_frame_done)
      else $error("error word carries data");

endmodule

### sim/dle_sfe_frame_checker.sv
// Stream checker for the DLE stuffed frame encoder: follows the item, register and
// stream channels, builds the framed words each item should produce and compares them.
// Depends on dle_sfe_pkg.
module dle_sfe_frame_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_command,
   input  logic [7:0]                          req_packet_id,
   input  logic [7:0]                          req_payload_length,
   input  logic [7:0]                          req_data_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [7:0]                          rsp_out_byte,
   input  logic                                rsp_last_of_run,
   input  logic                                rsp_frame_done,
   input  logic                                rsp_seq_error,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [dle_sfe_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [7:0]                          csr_wdata,
   output int                                  fail_count,
   output int                                  words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_done;
      logic       seq_error;
   } stream_word_type;

   stream_word_type framed_words[$];
   logic [7:0]      dle_byte;
   logic [7:0]      etx_byte;
   logic [7:0]      sum_so_far;
   logic [7:0]      payload_left;
   logic            frame_active;

   task automatic push_word(input logic [7:0] b, input logic done, input logic err);
      stream_word_type w;
      w.out_byte    = b;
      w.last_of_run = 1'b0;
      w.frame_done  = done;
      w.seq_error   = err;
      framed_words.push_back(w);
   endtask

   task automatic push_stuffed(input logic [7:0] b);
      if (b == dle_byte) begin
         push_word(dle_byte, 1'b0, 1'b0);
      end
      push_word(b, 1'b0, 1'b0);
   endtask

   // checksum is the two's complement of the running sum, then DLE ETX
   task automatic push_trailer();
      push_stuffed((sum_so_far ^ dle_sfe_pkg::AllOnes) + 8'd1);
      push_word(dle_byte, 1'b0, 1'b0);
      push_word(etx_byte, 1'b1, 1'b0);
      frame_active = 1'b0;
   endtask

   task automatic frame_item(input dle_sfe_pkg::item_type it);
      stream_word_type w;
      if (it.command == dle_sfe_pkg::CMD_START) begin
         // a start always opens a fresh frame, dropping any open one
         push_word(dle_byte, 1'b0, 1'b0);
         push_word(it.packet_id, 1'b0, 1'b0);
         push_stuffed(it.payload_length);
         sum_so_far   = it.packet_id + it.payload_length;
         payload_left = it.payload_length;
         frame_active = 1'b1;
         if (it.payload_length == 8'd0) begin
            push_trailer();
         end
      end else if (!frame_active) begin
         push_word(8'h00, 1'b0, 1'b1);
      end else begin
         push_stuffed(it.data_byte);
         sum_so_far   = sum_so_far + it.data_byte;
         payload_left = payload_left - 8'd1;
         if (payload_left == 8'd0) begin
            push_trailer();
         end
      end
      w = framed_words.pop_back();
      w.last_of_run = 1'b1;
      framed_words.push_back(w);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      stream_word_type       want;
      dle_sfe_pkg::item_type it;
      if (reset) begin
         framed_words.delete();
         dle_byte     = dle_sfe_pkg::EscapeReset;
         etx_byte     = dle_sfe_pkg::EndReset;
         sum_so_far   = 8'd0;
         payload_left = 8'd0;
         frame_active = 1'b0;
         fail_count   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (framed_words.size() == 0) begin
               $error("unexpected word: out_byte 0x%02h", rsp_out_byte);
               fail_count++;
            end else begin
               want = framed_words.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("last_of_run", 8'(want.last_of_run), 8'(rsp_last_of_run));
               check_field("frame_done", 8'(want.frame_done), 8'(rsp_frame_done));
               check_field("seq_error", 8'(want.seq_error), 8'(rsp_seq_error));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dle_sfe_pkg::CSR_ESCAPE: dle_byte = csr_wdata;
               dle_sfe_pkg::CSR_END:    etx_byte = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            it.command        = req_command;
            it.packet_id      = req_packet_id;
            it.payload_length = req_payload_length;
            it.data_byte      = req_data_byte;
            frame_item(it);
         end
      end
      words_pending = framed_words.size();
   end

endmodule

### sim/dle_stuffed_frame_encoder_tb.sv
// Testbench top for the DLE stuffed frame encoder: clock, reset, item and register
// stimulus, stream back-pressure, watchdog and verdict.
// Depends on dle_sfe_pkg, dle_stuffed_frame_encoder and dle_sfe_frame_checker.
module dle_stuffed_frame_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SettleCycles = 8;     // output register plus margin after the last word
   localparam int StallLimit   = 1000;  // cycles with no word moving on any channel

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_command = dle_sfe_pkg::CMD_START;
   logic [7:0]                          req_packet_id = 8'h00;
   logic [7:0]                          req_payload_length = 8'h00;
   logic [7:0]                          req_data_byte = 8'h00;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [7:0]                          rsp_out_byte;
   logic                                rsp_last_of_run;
   logic                                rsp_frame_done;
   logic                                rsp_seq_error;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [dle_sfe_pkg::CsrIdxWidth-1:0] csr_index = dle_sfe_pkg::CSR_ESCAPE;
   logic [7:0]                          csr_wdata = 8'h00;

   int         fail_count;
   int         words_pending;
   int         quiet_cycles = 0;
   logic       calm = 1'b0;          // set for a stretch with no idling on either side
   logic [7:0] escape_now = dle_sfe_pkg::EscapeReset;

   always #5 clock = ~clock;

   dle_stuffed_frame_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_packet_id      (req_packet_id),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_seq_error      (rsp_seq_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   dle_sfe_frame_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_packet_id      (req_packet_id),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_seq_error      (rsp_seq_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .words_pending      (words_pending)
   );

   // Stream side back-pressure: ~10% random stalls, none while calm.
   always @(posedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(99) >= 10);
   end

   // Watchdog: any word moving on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // One item word; valid stays up after the handshake so back-to-back items
   // never drop it within a step. An idle gap lowers it first.
   task automatic send_item(input logic cmd, input logic [7:0] id, input logic [7:0] len,
                            input logic [7:0] data);
      if (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_packet_id      <= id;
      req_payload_length <= len;
      req_data_byte      <= data;
      do @(posedge clock); while (!req_ready);
   endtask

   // unused fields on each item carry random junk
   task automatic start_frame(input logic [7:0] id, input logic [7:0] len);
      send_item(dle_sfe_pkg::CMD_START, id, len, 8'($urandom));
   endtask

   task automatic feed_byte(input logic [7:0] data);
      send_item(dle_sfe_pkg::CMD_DATA, 8'($urandom), 8'($urandom), data);
   endtask

   // Sender holds off until every expected word is out, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (words_pending != 0);
      @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes both framing bytes back to back; only done while drained.
   task automatic set_framing(input logic [7:0] dle, input logic [7:0] etx);
      csr_valid <= 1'b1;
      csr_index <= dle_sfe_pkg::CSR_ESCAPE;
      csr_wdata <= dle;
      do @(posedge clock); while (!csr_ready);
      csr_index <= dle_sfe_pkg::CSR_END;
      csr_wdata <= etx;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      escape_now = dle;
   endtask

   // payload bytes lean toward the escape byte so stuffing is hit often
   function automatic logic [7:0] pick_byte();
      return ($urandom_range(99) < 15) ? escape_now : 8'($urandom);
   endfunction

   // Mostly well-formed frames with random content; some frames get cut off
   // by a new start, some carry huge lengths, and stray data words show up.
   task automatic random_frames(input int count);
      int sent;
      int len;
      int stop_at;
      int k;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 6) begin
            feed_byte(pick_byte());
            sent++;
         end else begin
            if ($urandom_range(99) < 8) begin
               len     = $urandom_range(0, 255);
               stop_at = $urandom_range(0, 4);
            end else begin
               len = ($urandom_range(99) < 5 && escape_now < 24) ? escape_now
                                                                  : $urandom_range(0, 7);
               stop_at = ($urandom_range(99) < 10) ? $urandom_range(0, 7) : len;
            end
            if (stop_at > len) stop_at = len;
            start_frame(8'($urandom), 8'(len));
            sent++;
            for (k = 0; k < stop_at; k++) begin
               feed_byte(pick_byte());
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default framing, DLE 0x10 / ETX 0x03
      feed_byte(8'hFF);             // data with no frame open
      start_frame(8'h10, 8'h00);    // id equal to DLE goes out raw; zero length closes at once
      start_frame(8'hFF, 8'h10);    // length equal to DLE gets stuffed
      feed_byte(8'h10);
      feed_byte(8'h00);
      start_frame(8'h00, 8'h02);    // abandons the frame above
      feed_byte(8'hFF);
      feed_byte(8'hEF);             // checksum comes out as DLE, stuffed
      feed_byte(8'h42);             // frame already closed
      start_frame(8'hF0, 8'h00);    // zero length with a stuffed checksum
      start_frame(8'h55, 8'hFF);
      feed_byte(8'hAA);
      start_frame(8'hAA, 8'h01);
      feed_byte(8'h55);
      random_frames(120);
      drain();

      // DLE 0x00: zero-length frame with id 0 gives the longest run
      set_framing(8'h00, 8'hFF);
      start_frame(8'h00, 8'h00);
      start_frame(8'h80, 8'h01);
      feed_byte(8'h00);
      calm = 1'b1;
      random_frames(90);
      drain();
      calm = 1'b0;

      set_framing(8'hFF, 8'h00);
      start_frame(8'hFF, 8'hFF);
      start_frame(8'h01, 8'h00);    // checksum 0xFF equals DLE
      random_frames(90);
      drain();

      // DLE equal to ETX: no special handling
      set_framing(8'h5A, 8'h5A);
      start_frame(8'h5A, 8'h01);
      feed_byte(8'h5A);
      random_frames(60);
      drain();

      set_framing(dle_sfe_pkg::EscapeReset, dle_sfe_pkg::EndReset);
      random_frames(80);
      drain();

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
